[rtl/bil_pkg.sv]
// ----------------------------------------------------------------------------
// bil_pkg
// Shared constants and types for the keyed bilinear RGB565 sampler.
// ----------------------------------------------------------------------------
package bil_pkg;

   localparam logic [15:0] KEY_COLOR   = 16'h0000;
   localparam logic [15:0] RED_MASK    = 16'hF800;
   localparam logic [15:0] GREEN_MASK  = 16'h07E0;
   localparam logic [15:0] BLUE_MASK   = 16'h001F;
   localparam logic [8:0]  RED_MAX     = 9'd31;
   localparam logic [8:0]  GREEN_MAX   = 9'd63;
   localparam logic [8:0]  BLUE_MAX    = 9'd31;

   localparam logic [1:0]  SRC_INTERP   = 2'd0;
   localparam logic [1:0]  SRC_NEIGHBOR = 2'd1;
   localparam logic [1:0]  SRC_THRESH   = 2'd2;

   localparam int          CSR_INDEX_W  = 2;
   localparam int          CSR_DATA_W   = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_FLOOR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_FLOOR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_FLOOR  = 2'd2;

   typedef struct packed {
      logic [5:0] red;
      logic [6:0] green;
      logic [5:0] blue;
   } floor_type;

endpackage

[rtl/bilinear_rgb565_keyed_sample_unit.sv]
// ----------------------------------------------------------------------------
// bilinear_rgb565_keyed_sample_unit
// Keyed bilinear RGB565 sampler: front classifies and weights, a short queue
// decouples it from the back, which blends, clamps and keys the pixel.
// ----------------------------------------------------------------------------
// Path: the queue write at the accepting edge, then the product stage, then the
// output register; a stall holds an item where it is.
// Throughput: one item per cycle when neither the queue nor the output stalls,
// with combinational weight multipliers in the front and a product stage in the back.
// Reset: synchronous, clears queue pointers, stage valids and all floors.
// ----------------------------------------------------------------------------
module bilinear_rgb565_keyed_sample_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [7:0]                      req_frac_row,
   input  logic [7:0]                      req_frac_col,
   input  logic [15:0]                     req_pix_top_left,
   input  logic [15:0]                     req_pix_top_right,
   input  logic [15:0]                     req_pix_bottom_left,
   input  logic [15:0]                     req_pix_bottom_right,
   output logic                            empty,
   input  logic                            pop,
   output logic [15:0]                     rsp_pixel_out,
   output logic [1:0]                      rsp_result_source,
   input  logic                            csr_write_enable,
   input  logic [bil_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bil_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int WW    = 2 * FRAC_BITS + 1;
   localparam int QW    = 1 + 16 + 4 * WW + 64;
   localparam int DEPTH = 4;

   bil_pkg::floor_type floors_ff, floors_in;
   logic [QW-1:0]      entry;
   logic [QW-1:0]      q_data;
   logic               q_pop;
   logic               q_empty;

   always_comb begin
      floors_in = floors_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bil_pkg::CSR_RED_FLOOR:   floors_in.red   = csr_write_data[5:0];
            bil_pkg::CSR_GREEN_FLOOR: floors_in.green = csr_write_data;
            bil_pkg::CSR_BLUE_FLOOR:  floors_in.blue  = csr_write_data[5:0];
            default:                  floors_in = floors_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floors_ff <= '0;
      end else begin
         floors_ff <= floors_in;
      end
   end

   bil_front #(
      .FRAC_BITS (FRAC_BITS),
      .WW        (WW),
      .QW        (QW)
   ) u_front (
      .frac_row         (req_frac_row),
      .frac_col         (req_frac_col),
      .pix_top_left     (req_pix_top_left),
      .pix_top_right    (req_pix_top_right),
      .pix_bottom_left  (req_pix_bottom_left),
      .pix_bottom_right (req_pix_bottom_right),
      .entry            (entry)
   );

   bil_queue #(
      .WIDTH (QW),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (entry),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .q_full  (full),
      .q_empty (q_empty)
   );

   bil_back #(
      .FRAC_BITS (FRAC_BITS),
      .WW        (WW),
      .QW        (QW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .floors            (floors_ff),
      .pop               (pop),
      .empty             (empty),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_result_source (rsp_result_source)
   );

endmodule

[rtl/bil_front.sv]
// ----------------------------------------------------------------------------
// bil_front
// Classifies an item (key neighbor, maximum) and forms the four bilinear
// weights; packs everything into one queue entry.
// ----------------------------------------------------------------------------
module bil_front #(
   parameter int FRAC_BITS = 8,
   parameter int WW        = 2 * FRAC_BITS + 1,
   parameter int QW        = 1 + 16 + 4 * WW + 64
) (
   input  logic [7:0]    frac_row,
   input  logic [7:0]    frac_col,
   input  logic [15:0]   pix_top_left,
   input  logic [15:0]   pix_top_right,
   input  logic [15:0]   pix_bottom_left,
   input  logic [15:0]   pix_bottom_right,
   output logic [QW-1:0] entry
);

   logic [FRAC_BITS+7:0] a_wide;
   logic [FRAC_BITS+7:0] b_wide;
   logic [FRAC_BITS-1:0] a;
   logic [FRAC_BITS-1:0] b;
   logic [FRAC_BITS:0]   a_ext;
   logic [FRAC_BITS:0]   b_ext;
   logic [FRAC_BITS:0]   one_minus_a;
   logic [FRAC_BITS:0]   one_minus_b;
   logic [2*FRAC_BITS+1:0] prod [4];
   logic [15:0]          px [4];
   logic [15:0]          max_top;
   logic [15:0]          max_bottom;
   logic [15:0]          max_all;
   logic                 key;

   assign a_wide = {frac_row, {FRAC_BITS{1'b0}}};
   assign b_wide = {frac_col, {FRAC_BITS{1'b0}}};
   assign a      = a_wide[FRAC_BITS+7:8];
   assign b      = b_wide[FRAC_BITS+7:8];
   assign a_ext  = {1'b0, a};
   assign b_ext  = {1'b0, b};
   assign one_minus_a = {1'b1, {FRAC_BITS{1'b0}}} - a_ext;
   assign one_minus_b = {1'b1, {FRAC_BITS{1'b0}}} - b_ext;

   assign prod[0] = one_minus_a * one_minus_b;
   assign prod[1] = one_minus_a * b_ext;
   assign prod[2] = a_ext * one_minus_b;
   assign prod[3] = a_ext * b_ext;

   assign px[0] = pix_top_left;
   assign px[1] = pix_top_right;
   assign px[2] = pix_bottom_left;
   assign px[3] = pix_bottom_right;

   assign key = (px[0] == bil_pkg::KEY_COLOR) || (px[1] == bil_pkg::KEY_COLOR) ||
                (px[2] == bil_pkg::KEY_COLOR) || (px[3] == bil_pkg::KEY_COLOR);

   assign max_top    = (px[1] > px[0]) ? px[1] : px[0];
   assign max_bottom = (px[3] > px[2]) ? px[3] : px[2];
   assign max_all    = (max_bottom > max_top) ? max_bottom : max_top;

   always_comb begin
      entry = '0;
      entry[QW-1]      = key;
      entry[QW-2 -: 16] = max_all;
      for (int i = 0; i < 4; i++) begin
         entry[64 + WW*i +: WW] = prod[i][WW-1:0];
         entry[16*i +: 16]      = px[i];
      end
   end

endmodule

[rtl/bil_queue.sv]
// ----------------------------------------------------------------------------
// bil_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bil_queue #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             q_full,
   output logic             q_empty
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign q_full  = (count_ff == (PW+1)'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(DEPTH))
      else $error("queue count exceeds depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on write");

endmodule

[rtl/bil_back.sv]
// ----------------------------------------------------------------------------
// bil_back
// Blends the three channels of a queued item, clamps, applies threshold
// keying and holds the result in the output register.
// ----------------------------------------------------------------------------
module bil_back #(
   parameter int FRAC_BITS = 8,
   parameter int WW        = 2 * FRAC_BITS + 1,
   parameter int QW        = 1 + 16 + 4 * WW + 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  logic [QW-1:0]      q_data,
   output logic               q_pop,
   input  bil_pkg::floor_type floors,
   input  logic               pop,
   output logic               empty,
   output logic [15:0]        rsp_pixel_out,
   output logic [1:0]         rsp_result_source
);

   localparam int PRW = WW + 6;
   localparam int AW  = PRW + 2;

   logic [WW-1:0]  w [4];
   logic [5:0]     ch [3][4];
   logic           advance_p, advance_r;

   logic           p_valid_ff, p_valid_in;
   logic           p_key_ff;
   logic [15:0]    p_max_ff;
   logic [PRW-1:0] p_prod_ff [3][4];
   logic [PRW-1:0] p_prod_in [3][4];

   logic           r_valid_ff, r_valid_in;
   logic [15:0]    r_pixel_ff, r_pixel_in;
   logic [1:0]     r_src_ff, r_src_in;

   logic [AW-1:0]  acc [3];
   logic [8:0]     lvl [3];
   logic [8:0]     lvl_max [3];
   logic [8:0]     clamped [3];
   logic           below;

   assign advance_r = !r_valid_ff || pop;
   assign advance_p = !p_valid_ff || advance_r;
   assign q_pop     = advance_p && !q_empty;
   assign p_valid_in = advance_p ? !q_empty : p_valid_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         w[i]     = q_data[64 + WW*i +: WW];
         ch[0][i] = {1'b0, q_data[16*i + 11 +: 5]};
         ch[1][i] = q_data[16*i + 5 +: 6];
         ch[2][i] = {1'b0, q_data[16*i +: 5]};
      end
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 4; i++) begin
            p_prod_in[c][i] = {6'd0, w[i]} * {{(PRW-6){1'b0}}, ch[c][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p_key_ff  <= q_data[QW-1];
         p_max_ff  <= q_data[QW-2 -: 16];
         p_prod_ff <= p_prod_in;
      end
   end

   assign lvl_max[0] = bil_pkg::RED_MAX;
   assign lvl_max[1] = bil_pkg::GREEN_MAX;
   assign lvl_max[2] = bil_pkg::BLUE_MAX;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = {2'b00, p_prod_ff[c][0]} + {2'b00, p_prod_ff[c][1]} +
                  {2'b00, p_prod_ff[c][2]} + {2'b00, p_prod_ff[c][3]};
         lvl[c] = acc[c][AW-1:2*FRAC_BITS];
         clamped[c] = (lvl[c] > lvl_max[c]) ? lvl_max[c] : lvl[c];
      end
      below = (clamped[0] < {3'd0, floors.red}) &&
              (clamped[1] < {2'd0, floors.green}) &&
              (clamped[2] < {3'd0, floors.blue});
      if (p_key_ff) begin
         r_pixel_in = p_max_ff;
         r_src_in   = bil_pkg::SRC_NEIGHBOR;
      end else if (below) begin
         r_pixel_in = bil_pkg::KEY_COLOR;
         r_src_in   = bil_pkg::SRC_THRESH;
      end else begin
         r_pixel_in = {clamped[0][4:0], clamped[1][5:0], clamped[2][4:0]};
         r_src_in   = bil_pkg::SRC_INTERP;
      end
      r_valid_in = advance_r ? p_valid_ff : r_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_r && p_valid_ff) begin
         r_pixel_ff <= r_pixel_in;
         r_src_ff   <= r_src_in;
      end
   end

   assign empty             = !r_valid_ff;
   assign rsp_pixel_out     = r_pixel_ff;
   assign rsp_result_source = r_src_ff;

   a_thresh_is_key: assert property (@(posedge clock) disable iff (reset)
      (r_valid_ff && r_src_ff == bil_pkg::SRC_THRESH) |-> (r_pixel_ff == bil_pkg::KEY_COLOR))
      else $error("threshold keyed result is not the key color");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && !advance_p) |=> p_valid_ff)
      else $error("product stage lost an item while stalled");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Runs the keyed bilinear RGB565 sampler through a table of corner cases,
// then through random phases, each under its own set of channel floors.
// Both queue sides idle at random but in one phase. Every output pixel and its
// source code are checked in order against the table or a blend/key model.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS   = 8;
   localparam int SHIFT_UP    = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
   localparam int SHIFT_DN    = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 85;
   localparam int SETTLE      = 10;
   localparam int DIR_COUNT   = 19;

   typedef struct packed {
      logic [7:0]  frac_row;
      logic [7:0]  frac_col;
      logic [15:0] pix_tl;
      logic [15:0] pix_tr;
      logic [15:0] pix_bl;
      logic [15:0] pix_br;
   } sample_req_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic [1:0]  source;
   } sample_rsp_type;

   typedef struct packed {
      bil_pkg::floor_type floors;
      sample_req_type     req;
      logic               typed;
      sample_rsp_type     want;
   } dir_row_type;

   localparam bil_pkg::floor_type FL_RESET = '{6'd0, 7'd0, 6'd0};
   localparam bil_pkg::floor_type FL_ABOVE = '{6'd32, 7'd64, 6'd32};
   localparam bil_pkg::floor_type FL_TOP   = '{6'd31, 7'd63, 6'd31};
   localparam bil_pkg::floor_type FL_ONE   = '{6'd1, 7'd1, 6'd1};
   localparam bil_pkg::floor_type FL_RED0  = '{6'd0, 7'd64, 6'd32};
   localparam sample_rsp_type PREDICT = '{bil_pkg::KEY_COLOR, bil_pkg::SRC_INTERP};

   localparam logic [15:0] EDGE_PIXELS [6] =
      '{16'hFFFF, 16'h0001, bil_pkg::RED_MASK, bil_pkg::GREEN_MASK,
        bil_pkg::BLUE_MASK, 16'h8000};

   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{FL_RESET, '{8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        1'b1, '{bil_pkg::KEY_COLOR, bil_pkg::SRC_NEIGHBOR}},
      '{FL_RESET, '{8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'h1234, 16'h8000},
        1'b1, '{16'hFFFF, bil_pkg::SRC_NEIGHBOR}},
      '{FL_RESET, '{8'h5A, 8'hA5, 16'h0001, 16'h0002, 16'h7FFF, 16'h0000},
        1'b1, '{16'h7FFF, bil_pkg::SRC_NEIGHBOR}},
      '{FL_RESET, '{8'h00, 8'h00, 16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{16'h1234, bil_pkg::SRC_INTERP}},
      '{FL_RESET, '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{16'hFFFF, bil_pkg::SRC_INTERP}},
      '{FL_RESET, '{8'h80, 8'h80, 16'h0001, 16'h0001, 16'h0001, 16'h0001},
        1'b1, '{16'h0001, bil_pkg::SRC_INTERP}},
      '{FL_RESET, '{8'hFF, 8'h00, 16'hF800, 16'h07E0, 16'h001F, 16'hFFFF},
        1'b0, PREDICT},
      '{FL_RESET, '{8'h00, 8'hFF, 16'hF800, 16'h07E0, 16'h001F, 16'hFFFF},
        1'b0, PREDICT},
      '{FL_RESET, '{8'h80, 8'h80, 16'hF81F, 16'h07E0, 16'hFFE0, 16'h001F},
        1'b0, PREDICT},
      '{FL_RESET, '{8'hAA, 8'h55, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555},
        1'b0, PREDICT},
      '{FL_ABOVE, '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{bil_pkg::KEY_COLOR, bil_pkg::SRC_THRESH}},
      '{FL_ABOVE, '{8'h37, 8'hC8, 16'h1234, 16'h4321, 16'hBEEF, 16'hCAFE},
        1'b1, '{bil_pkg::KEY_COLOR, bil_pkg::SRC_THRESH}},
      '{FL_ABOVE, '{8'h10, 8'hF0, 16'h0000, 16'h1111, 16'h0F0F, 16'h00FF},
        1'b1, '{16'h1111, bil_pkg::SRC_NEIGHBOR}},
      '{FL_TOP, '{8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{16'hFFFF, bil_pkg::SRC_INTERP}},
      '{FL_TOP, '{8'h00, 8'h00, 16'hF7DE, 16'hF7DE, 16'hF7DE, 16'hF7DE},
        1'b1, '{bil_pkg::KEY_COLOR, bil_pkg::SRC_THRESH}},
      '{FL_TOP, '{8'h00, 8'h00, 16'hF7FE, 16'hF7FE, 16'hF7FE, 16'hF7FE},
        1'b1, '{16'hF7FE, bil_pkg::SRC_INTERP}},
      '{FL_ONE, '{8'h80, 8'h80, 16'h0001, 16'h0020, 16'h0800, 16'h0001},
        1'b0, PREDICT},
      '{FL_ONE, '{8'h00, 8'h00, 16'h0841, 16'h0841, 16'h0841, 16'h0841},
        1'b1, '{16'h0841, bil_pkg::SRC_INTERP}},
      '{FL_RED0, '{8'h00, 8'h00, 16'h0001, 16'h0001, 16'h0001, 16'h0001},
        1'b1, '{16'h0001, bil_pkg::SRC_INTERP}}
   };

   logic                            clock;
   logic                            reset;
   logic                            push;
   logic                            full;
   logic                            empty;
   logic                            pop;
   sample_req_type                  req;
   logic [15:0]                     rsp_pixel_out;
   logic [1:0]                      rsp_result_source;
   logic                            csr_write_enable;
   logic [bil_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bil_pkg::CSR_DATA_W-1:0]  csr_write_data;

   bil_pkg::floor_type floors_now = FL_RESET;
   sample_rsp_type     pending_samples [$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   bit                 steady = 1'b0;

   bilinear_rgb565_keyed_sample_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_frac_row        (req.frac_row),
      .req_frac_col        (req.frac_col),
      .req_pix_top_left    (req.pix_tl),
      .req_pix_top_right   (req.pix_tr),
      .req_pix_bottom_left (req.pix_bl),
      .req_pix_bottom_right(req.pix_br),
      .empty               (empty),
      .pop                 (pop),
      .rsp_pixel_out       (rsp_pixel_out),
      .rsp_result_source   (rsp_result_source),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   function automatic logic [63:0] channel_blend(input logic [63:0] wt [4],
                                                 input logic [63:0] ch [4],
                                                 input logic [63:0] top);
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < 4; i++)
         acc += wt[i] * ch[i];
      acc = acc >> (2 * FRAC_BITS);
      return (acc > top) ? top : acc;
   endfunction

   function automatic sample_rsp_type sample_pixel(input sample_req_type rq,
                                                   input bil_pkg::floor_type fl);
      logic [15:0] px [4];
      logic [63:0] wt [4], cr [4], cg [4], cb [4];
      logic [63:0] one, a, b, r, g, bl;
      sample_rsp_type res;
      px = '{rq.pix_tl, rq.pix_tr, rq.pix_bl, rq.pix_br};
      if (px[0] == bil_pkg::KEY_COLOR || px[1] == bil_pkg::KEY_COLOR ||
          px[2] == bil_pkg::KEY_COLOR || px[3] == bil_pkg::KEY_COLOR) begin
         res.pixel = px[0];
         for (int i = 1; i < 4; i++)
            if (px[i] > res.pixel) res.pixel = px[i];
         res.source = bil_pkg::SRC_NEIGHBOR;
         return res;
      end
      one = 64'd1 << FRAC_BITS;
      a = (64'(rq.frac_row) << SHIFT_UP) >> SHIFT_DN;
      b = (64'(rq.frac_col) << SHIFT_UP) >> SHIFT_DN;
      wt = '{(one - a) * (one - b), (one - a) * b, a * (one - b), a * b};
      for (int i = 0; i < 4; i++) begin
         cr[i] = 64'((px[i] & bil_pkg::RED_MASK) >> 11);
         cg[i] = 64'((px[i] & bil_pkg::GREEN_MASK) >> 5);
         cb[i] = 64'(px[i] & bil_pkg::BLUE_MASK);
      end
      r  = channel_blend(wt, cr, 64'(bil_pkg::RED_MAX));
      g  = channel_blend(wt, cg, 64'(bil_pkg::GREEN_MAX));
      bl = channel_blend(wt, cb, 64'(bil_pkg::BLUE_MAX));
      if (r < fl.red && g < fl.green && bl < fl.blue) begin
         res.pixel  = bil_pkg::KEY_COLOR;
         res.source = bil_pkg::SRC_THRESH;
      end else begin
         res.pixel  = {r[4:0], g[5:0], bl[4:0]};
         res.source = bil_pkg::SRC_INTERP;
      end
      return res;
   endfunction

   function automatic logic [15:0] rand_pixel();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return bil_pkg::KEY_COLOR;
      if (pick < 30)
         return {5'($urandom_range(7)), 6'($urandom_range(15)), 5'($urandom_range(7))};
      if (pick < 40) return EDGE_PIXELS[$urandom_range(5)];
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] rand_frac();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return 8'h00;
      if (pick < 30) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic bil_pkg::floor_type rand_floors();
      bil_pkg::floor_type fl;
      if ($urandom_range(1) == 0)
         fl = '{6'($urandom_range(8)), 7'($urandom_range(16)), 6'($urandom_range(8))};
      else
         fl = '{6'($urandom_range(32)), 7'($urandom_range(64)), 6'($urandom_range(32))};
      return fl;
   endfunction

   task automatic push_item(input sample_req_type it, input sample_rsp_type want);
      while (!steady && $urandom_range(99) < 19) begin
         push <= 1'b0;
         req  <= {$urandom(), 24'($urandom())};
         @(negedge clock);
      end
      push <= 1'b1;
      req  <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_samples.push_back(want);
      @(negedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
   endtask

   task automatic write_floors(input bil_pkg::floor_type fl);
      csr_write_enable <= 1'b1;
      csr_index        <= bil_pkg::CSR_RED_FLOOR;
      csr_write_data   <= bil_pkg::CSR_DATA_W'(fl.red);
      @(negedge clock);
      csr_index        <= bil_pkg::CSR_GREEN_FLOOR;
      csr_write_data   <= fl.green;
      @(negedge clock);
      csr_index        <= bil_pkg::CSR_BLUE_FLOOR;
      csr_write_data   <= bil_pkg::CSR_DATA_W'(fl.blue);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      floors_now = fl;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock)
      pop <= steady || ($urandom_range(99) >= 19);

   always @(posedge clock) begin
      sample_rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_samples.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected item: pixel %h source %0d",
                        rsp_pixel_out, rsp_result_source);
            mismatch_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_pixel_out !== want.pixel || rsp_result_source !== want.source) begin
               if (mismatch_count < 10)
                  $display("mismatch: pixel exp %h got %h, source exp %0d got %0d",
                           want.pixel, rsp_pixel_out, want.source, rsp_result_source);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      sample_req_type it;
      dir_row_type    row;
      reset            = 1'b1;
      push             = 1'b0;
      req              = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIR_COUNT; n++) begin
         row = DIR_ROWS[n];
         if (row.floors != floors_now) begin
            drain();
            write_floors(row.floors);
         end
         push_item(row.req, row.typed ? row.want : sample_pixel(row.req, floors_now));
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_floors(p == 0 ? FL_RESET : (p == 1 ? FL_ABOVE : rand_floors()));
         steady = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = '{rand_frac(), rand_frac(), rand_pixel(), rand_pixel(),
                   rand_pixel(), rand_pixel()};
            push_item(it, sample_pixel(it, floors_now));
         end
      end

      drain();
      steady = 1'b0;
      repeat (SETTLE) @(negedge clock);
      if (mismatch_count == 0 && pending_samples.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
